// ===== sv/sirt_pkg.sv =====
// Shared types, constants and codes for the sorted interval reservation table.
package sirt_pkg;

  localparam int unsigned DEPTH = 16;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned TIME_W = 11;
  localparam int unsigned ROOM_W = 8;
  localparam int unsigned KEY_W = 5;

  localparam logic [TIME_W-1:0] DAY_MIN = TIME_W'(1440);
  localparam logic [TIME_W-1:0] BEYOND_DAY = TIME_W'(1500);
  localparam logic [KEY_W-1:0] MAX_HOUR = KEY_W'(24);

  // Operation codes
  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_FIND = 2'd1;
  localparam logic [1:0] OP_REMOVE = 2'd2;

  // Status codes
  localparam logic [2:0] ST_OK = 3'd0;
  localparam logic [2:0] ST_OVERLAP = 3'd1;
  localparam logic [2:0] ST_FULL = 3'd2;
  localparam logic [2:0] ST_INVALID = 3'd3;
  localparam logic [2:0] ST_NOTFOUND = 3'd4;
  localparam logic [2:0] ST_KEYRANGE = 3'd5;

  typedef struct packed {
    logic [TIME_W-1:0] start_min;
    logic [TIME_W-1:0] end_min;
    logic [ROOM_W-1:0] room_num;
  } entry_t;

  // Commit strobes from the controller to every cell
  typedef struct packed {
    logic insert_en;
    logic remove_en;
  } cell_ctl_t;

  // Flags that ripple from a cell to its right neighbor
  typedef struct packed {
    logic shift;
    logic found;
  } chain_t;

endpackage

// ===== sv/sirt_cell.sv =====
// One slot of the reservation chain: holds an entry and shifts with its neighbors.
module sirt_cell
  import sirt_pkg::*;
(
  input  logic              clk_i,
  input  logic              head_i,
  input  logic              in_use_i,
  input  logic              tail_i,
  input  logic [TIME_W-1:0] new_start_i,
  input  logic [TIME_W-1:0] target_i,
  input  entry_t            new_entry_i,
  input  entry_t            left_entry_i,
  input  entry_t            right_entry_i,
  input  chain_t            chain_i,
  input  cell_ctl_t         ctl_i,
  output chain_t            chain_o,
  output entry_t            entry_o,
  output logic              first_shift_o,
  output logic              match_o
);

  entry_t entry_q;
  entry_t entry_d;
  logic   before_here;
  logic   key_eq;

  // Decide whether the new start sorts ahead of this entry
  assign before_here = head_i ? (new_start_i <= entry_q.start_min)
                              : (new_start_i < entry_q.start_min);
  assign key_eq = in_use_i && (entry_q.start_min == target_i);

  // Pass shift and found flags to the right neighbor
  assign chain_o.shift = in_use_i && (chain_i.shift || before_here);
  assign chain_o.found = chain_i.found || key_eq;

  assign first_shift_o = chain_o.shift && !chain_i.shift;
  assign match_o = key_eq && !chain_i.found;
  assign entry_o = entry_q;

  // Select the next content: left neighbor, new item, right neighbor or its own
  always_comb begin
    entry_d = entry_q;
    if (ctl_i.insert_en) begin
      if (chain_i.shift) begin
        entry_d = left_entry_i;
      end else if (chain_o.shift || tail_i) begin
        entry_d = new_entry_i;
      end
    end else if (ctl_i.remove_en) begin
      if (chain_o.found) begin
        entry_d = right_entry_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

endmodule

// ===== sv/sorted_interval_reservation_table.sv =====
// Top level of the sorted interval reservation table: controller and cell chain.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one command: insert an
//   interval (start_min, end_min, room_num), or find / remove the first entry
//   that starts at key_hour * 60. Output channel (out_valid_o / out_stall_i)
//   returns exactly one result per command: status, the hit entry for a
//   successful find (zeros otherwise) and the entry count after the command.
//   Entries live in a chain of DEPTH cells kept sorted by start time; all
//   cells compare in parallel and shift by one place in the same cycle.
// Flow control:
//   A command is registered at acceptance and then evaluated; the result
//   is loaded into the output register. Only one command is in flight.
//   The evaluation waits while a previous result is still held by a
//   stalled receiver; in_stall_o stays high for that time, and a held
//   result does not change.
// Reset:
//   Clears the entry count, the in-flight flag and the output valid. Cell
//   contents are not cleared; only slots below the count are ever used.
module sorted_interval_reservation_table
  import sirt_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [1:0]        operation_i,
  input  logic [TIME_W-1:0] start_min_i,
  input  logic [TIME_W-1:0] end_min_i,
  input  logic [ROOM_W-1:0] room_num_i,
  input  logic [KEY_W-1:0]  key_hour_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [2:0]        status_o,
  output logic [TIME_W-1:0] hit_start_o,
  output logic [TIME_W-1:0] hit_end_o,
  output logic [ROOM_W-1:0] hit_room_o,
  output logic [4:0]        entry_count_o
);

  logic              busy_q;
  logic              out_valid_q;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [1:0]        op_q;
  logic [KEY_W-1:0]  key_q;
  entry_t            req_q;
  logic [2:0]        status_q, status_d;
  entry_t            hit_q, hit_d;

  logic              in_accept;
  logic              exec;
  logic [TIME_W-1:0] target;
  cell_ctl_t         ctl;

  entry_t            cell_entry [DEPTH];
  chain_t            chain_in [DEPTH];
  chain_t            chain_out [DEPTH];
  logic [DEPTH-1:0]  in_use;
  logic [DEPTH-1:0]  tail;
  logic [DEPTH-1:0]  first_shift;
  logic [DEPTH-1:0]  match;
  logic [DEPTH-1:0]  prev_sel;

  logic [TIME_W-1:0] next_start;
  logic [TIME_W-1:0] prev_end;
  entry_t            match_entry;
  logic              any_shift;
  logic              any_match;
  logic              has_prev;
  logic              bad_interval;
  logic              overlap;
  logic              key_bad;

  assign in_accept = in_valid_i && !busy_q;
  assign in_stall_o = busy_q;
  assign exec = busy_q && (!out_valid_q || !out_stall_i);

  // key_hour * 60 as (key << 6) - (key << 2)
  assign target = (TIME_W'(key_q) << 6) - (TIME_W'(key_q) << 2);

  // Slot occupancy and the first free slot
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      in_use[i] = CNT_W'(i) < count_q;
      tail[i] = CNT_W'(i) == count_q;
    end
  end

  // Build the chain of cells
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    if (i == 0) begin : g_head
      assign chain_in[i] = '0;
    end else begin : g_body
      assign chain_in[i] = chain_out[i-1];
    end

    sirt_cell u_cell (
      .clk_i         (clk_i),
      .head_i        (i == 0),
      .in_use_i      (in_use[i]),
      .tail_i        (tail[i]),
      .new_start_i   (req_q.start_min),
      .target_i      (target),
      .new_entry_i   (req_q),
      .left_entry_i  (cell_entry[(i == 0) ? 0 : i - 1]),
      .right_entry_i (cell_entry[(i == DEPTH - 1) ? i : i + 1]),
      .chain_i       (chain_in[i]),
      .ctl_i         (ctl),
      .chain_o       (chain_out[i]),
      .entry_o       (cell_entry[i]),
      .first_shift_o (first_shift[i]),
      .match_o       (match[i])
    );
  end

  // Mark the entry just before the insert position
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      if (i == DEPTH - 1) begin
        prev_sel[i] = in_use[i] && !chain_out[i].shift;
      end else begin
        prev_sel[i] = in_use[i] && !chain_out[i].shift &&
                      (chain_out[i+1].shift || !in_use[i+1]);
      end
    end
  end

  // Gather neighbor times and the find hit from one-hot selects
  always_comb begin
    next_start = '0;
    prev_end = '0;
    match_entry = '0;
    for (int i = 0; i < DEPTH; i++) begin
      next_start = next_start | (first_shift[i] ? cell_entry[i].start_min : '0);
      prev_end = prev_end | (prev_sel[i] ? cell_entry[i].end_min : '0);
      match_entry = match_entry | (match[i] ? cell_entry[i] : '0);
    end
  end

  assign any_shift = |first_shift;
  assign any_match = |match;
  assign has_prev = in_use[0] && !chain_out[0].shift;
  assign bad_interval = (req_q.start_min > req_q.end_min) || (req_q.end_min > DAY_MIN);
  assign overlap = (has_prev && (req_q.start_min < prev_end)) ||
                   (req_q.end_min > (any_shift ? next_start : BEYOND_DAY));
  assign key_bad = key_q > MAX_HOUR;

  // Evaluate the command and produce commit strobes
  always_comb begin
    status_d = ST_INVALID;
    hit_d = '0;
    ctl = '0;
    count_d = count_q;
    unique case (op_q)
      OP_INSERT: begin
        if (bad_interval) begin
          status_d = ST_INVALID;
        end else if (overlap) begin
          status_d = ST_OVERLAP;
        end else if (count_q >= CNT_W'(DEPTH)) begin
          status_d = ST_FULL;
        end else begin
          status_d = ST_OK;
          ctl.insert_en = exec;
          count_d = count_q + CNT_W'(1);
        end
      end
      OP_FIND: begin
        if (key_bad) begin
          status_d = ST_KEYRANGE;
        end else if (!any_match) begin
          status_d = ST_NOTFOUND;
        end else begin
          status_d = ST_OK;
          hit_d = match_entry;
        end
      end
      OP_REMOVE: begin
        if (key_bad) begin
          status_d = ST_KEYRANGE;
        end else if (!any_match) begin
          status_d = ST_NOTFOUND;
        end else begin
          status_d = ST_OK;
          ctl.remove_en = exec;
          count_d = count_q - CNT_W'(1);
        end
      end
      default: begin
        status_d = ST_INVALID;
      end
    endcase
  end

  // Control state: in-flight flag, output valid, entry count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      out_valid_q <= 1'b0;
      count_q <= '0;
    end else begin
      if (in_accept) begin
        busy_q <= 1'b1;
      end else if (exec) begin
        busy_q <= 1'b0;
      end
      if (exec) begin
        out_valid_q <= 1'b1;
        count_q <= count_d;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Capture the request and the result transaction
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      op_q <= operation_i;
      key_q <= key_hour_i;
      req_q.start_min <= start_min_i;
      req_q.end_min <= end_min_i;
      req_q.room_num <= room_num_i;
    end
    if (exec) begin
      status_q <= status_d;
      hit_q <= hit_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o = status_q;
  assign hit_start_o = hit_q.start_min;
  assign hit_end_o = hit_q.end_min;
  assign hit_room_o = hit_q.room_num;
  assign entry_count_o = 5'(count_q);

endmodule

// ===== tb/sv/tb_sorted_interval_reservation_table.sv =====
// Self-checking testbench for the sorted interval reservation table.
import sirt_pkg::*;

// One result transaction: status, hit entry and count after the command
typedef struct packed {
  logic [2:0]        status;
  logic [TIME_W-1:0] hit_start;
  logic [TIME_W-1:0] hit_end;
  logic [ROOM_W-1:0] hit_room;
  logic [4:0]        entry_count;
} booking_result_t;

// Mirror of the sorted table; predicts each command and checks results in order
class reservation_scoreboard;
  logic [TIME_W-1:0] start_tbl [DEPTH];
  logic [TIME_W-1:0] end_tbl [DEPTH];
  logic [ROOM_W-1:0] room_tbl [DEPTH];
  int unsigned       n_entries;
  booking_result_t   awaited_results [$];
  int unsigned       errors;

  function new();
    n_entries = 0;
    errors = 0;
  endfunction

  // Apply an accepted command to the mirror and queue its expected result
  function void note_command(logic [1:0] op, logic [TIME_W-1:0] s, logic [TIME_W-1:0] e,
                             logic [ROOM_W-1:0] room, logic [KEY_W-1:0] key);
    booking_result_t   want;
    int                pos;
    int                idx;
    int                i;
    bit                has_prev;
    logic [TIME_W-1:0] prev_end;
    logic [TIME_W-1:0] next_start;
    want = '0;
    case (op)
      OP_INSERT: begin
        if (s > e || e > DAY_MIN) begin
          want.status = ST_INVALID;
        end else begin
          pos = 0;
          has_prev = 1'b0;
          prev_end = '0;
          next_start = (n_entries == 0) ? BEYOND_DAY : start_tbl[0];
          // Slot goes before the first later entry whose start exceeds the new start
          if (n_entries != 0 && s > start_tbl[0]) begin
            pos = n_entries;
            next_start = BEYOND_DAY;
            for (i = int'(n_entries) - 1; i >= 1; i--) begin
              if (s < start_tbl[i]) begin
                pos = i;
                next_start = start_tbl[i];
              end
            end
            prev_end = end_tbl[pos-1];
            has_prev = 1'b1;
          end
          if ((has_prev && s < prev_end) || e > next_start) begin
            want.status = ST_OVERLAP;
          end else if (n_entries >= DEPTH) begin
            want.status = ST_FULL;
          end else begin
            for (i = n_entries; i > pos; i--) begin
              start_tbl[i] = start_tbl[i-1];
              end_tbl[i] = end_tbl[i-1];
              room_tbl[i] = room_tbl[i-1];
            end
            start_tbl[pos] = s;
            end_tbl[pos] = e;
            room_tbl[pos] = room;
            n_entries++;
            want.status = ST_OK;
          end
        end
      end
      OP_FIND, OP_REMOVE: begin
        // First entry that starts on the whole hour
        idx = n_entries;
        for (i = int'(n_entries) - 1; i >= 0; i--) begin
          if (start_tbl[i] == key * 60) idx = i;
        end
        if (key > MAX_HOUR) begin
          want.status = ST_KEYRANGE;
        end else if (idx >= int'(n_entries)) begin
          want.status = ST_NOTFOUND;
        end else if (op == OP_FIND) begin
          want.status = ST_OK;
          want.hit_start = start_tbl[idx];
          want.hit_end = end_tbl[idx];
          want.hit_room = room_tbl[idx];
        end else begin
          for (i = idx; i + 1 < int'(n_entries); i++) begin
            start_tbl[i] = start_tbl[i+1];
            end_tbl[i] = end_tbl[i+1];
            room_tbl[i] = room_tbl[i+1];
          end
          n_entries--;
          want.status = ST_OK;
        end
      end
      default: want.status = ST_INVALID;
    endcase
    want.entry_count = 5'(n_entries);
    awaited_results.push_back(want);
  endfunction

  function void compare_field(string name, int unsigned want, int unsigned seen);
    if (want != seen) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, seen);
    end
  endfunction

  // Match a result transaction against the oldest expectation
  function void check_result(booking_result_t seen);
    booking_result_t want;
    if (awaited_results.size() == 0) begin
      errors++;
      $display("%0t: unexpected result, expected none, actual status %0d count %0d",
               $time, seen.status, seen.entry_count);
      return;
    end
    want = awaited_results.pop_front();
    compare_field("status", want.status, seen.status);
    compare_field("hit_start", want.hit_start, seen.hit_start);
    compare_field("hit_end", want.hit_end, seen.hit_end);
    compare_field("hit_room", want.hit_room, seen.hit_room);
    compare_field("entry_count", want.entry_count, seen.entry_count);
  endfunction
endclass

module tb_sorted_interval_reservation_table;
  localparam logic [1:0] OP_NONE = 2'd3;
  localparam int unsigned PHASE_ITEMS = 583;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned WATCHDOG_LIMIT = 3000;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid_i = 1'b0;
  logic              in_stall_o;
  logic [1:0]        operation_i = OP_INSERT;
  logic [TIME_W-1:0] start_min_i = '0;
  logic [TIME_W-1:0] end_min_i = '0;
  logic [ROOM_W-1:0] room_num_i = '0;
  logic [KEY_W-1:0]  key_hour_i = '0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  logic [2:0]        status_o;
  logic [TIME_W-1:0] hit_start_o;
  logic [TIME_W-1:0] hit_end_o;
  logic [ROOM_W-1:0] hit_room_o;
  logic [4:0]        entry_count_o;

  int unsigned src_idle_pct = 0;
  int unsigned sink_stall_pct = 0;
  logic        burst_req = 1'b0;
  logic        burst_done = 1'b0;
  int unsigned quiet_cycles = 0;

  reservation_scoreboard sb = new();

  sorted_interval_reservation_table u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .operation_i   (operation_i),
    .start_min_i   (start_min_i),
    .end_min_i     (end_min_i),
    .room_num_i    (room_num_i),
    .key_hour_i    (key_hour_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .status_o      (status_o),
    .hit_start_o   (hit_start_o),
    .hit_end_o     (hit_end_o),
    .hit_room_o    (hit_room_o),
    .entry_count_o (entry_count_o)
  );

  always #10 clk_i = ~clk_i;

  // Observe both channels at the clock edge
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o) begin
      sb.note_command(operation_i, start_min_i, end_min_i, room_num_i, key_hour_i);
    end
    if (rst_ni && out_valid_o && !out_stall_i) begin
      sb.check_result('{status: status_o, hit_start: hit_start_o, hit_end: hit_end_o,
                        hit_room: hit_room_o, entry_count: entry_count_o});
    end
  end

  // End the run if no transaction moves for too long
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL sorted_interval_reservation_table");
      $finish;
    end
  end

  // Result receiver: random stalls, plus one long hold-off on request
  initial begin
    forever begin
      @(posedge clk_i);
      if (burst_req && !burst_done) begin
        burst_done = 1'b1;
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES - 1) @(posedge clk_i);
      end else begin
        out_stall_i <= ($urandom_range(99) < sink_stall_pct);
      end
    end
  end

  // Offer one command and hold it until the block takes it
  task automatic send_cmd(input logic [1:0] op, input logic [TIME_W-1:0] s,
                          input logic [TIME_W-1:0] e, input logic [ROOM_W-1:0] room,
                          input logic [KEY_W-1:0] key);
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    operation_i <= op;
    start_min_i <= s;
    end_min_i <= e;
    room_num_i <= room;
    key_hour_i <= key;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  // Mostly hour-aligned short bookings and lookups, with some raw noise
  task automatic send_random(input int unsigned ins_share);
    int unsigned       pick;
    logic [1:0]        op;
    logic [TIME_W-1:0] s;
    logic [TIME_W-1:0] e;
    logic [KEY_W-1:0]  key;
    pick = $urandom_range(99);
    s = TIME_W'($urandom_range(23) * 60);
    if ($urandom_range(3) == 0) s = s + TIME_W'($urandom_range(59));
    e = s + TIME_W'($urandom_range(90));
    if (e > DAY_MIN) e = DAY_MIN;
    key = ($urandom_range(9) == 0) ? KEY_W'($urandom_range(31)) : KEY_W'($urandom_range(24));
    if (pick < ins_share) begin
      op = OP_INSERT;
    end else if (pick < 92) begin
      op = ($urandom_range(1) == 0) ? OP_FIND : OP_REMOVE;
    end else begin
      op = ($urandom_range(1) == 0) ? OP_INSERT : OP_NONE;
      s = TIME_W'($urandom());
      e = TIME_W'($urandom());
    end
    send_cmd(op, s, e, ROOM_W'($urandom()), key);
  endtask

  initial begin
    int h;
    int k;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Empty table lookups, unknown operation, invalid intervals
    send_cmd(OP_FIND, 0, 0, 0, 0);
    send_cmd(OP_REMOVE, 0, 0, 0, 31);
    send_cmd(OP_NONE, '1, '1, '1, '1);
    send_cmd(OP_INSERT, 5, 3, 8'h5a, 0);
    send_cmd(OP_INSERT, 0, 1441, 8'h11, 0);
    send_cmd(OP_INSERT, '1, '1, 8'h22, 0);
    // First insert into an empty table, then in front of entry zero
    send_cmd(OP_INSERT, 600, 660, 8'hff, 0);
    send_cmd(OP_INSERT, 540, 600, 8'h00, 0);
    send_cmd(OP_INSERT, 540, 540, 8'h33, 0);
    // Overlap with the next start, then with the previous end
    send_cmd(OP_INSERT, 300, 541, 8'h44, 0);
    send_cmd(OP_INSERT, 650, 700, 8'h55, 0);
    // Append at the end of the day
    send_cmd(OP_INSERT, 1440, 1440, 8'h66, 0);
    send_cmd(OP_FIND, 0, 0, 0, 9);
    send_cmd(OP_FIND, 0, 0, 0, 25);
    send_cmd(OP_REMOVE, 0, 0, 0, 10);
    // Fill up hour by hour until the table reports full
    for (h = 10; h <= 23; h++) begin
      send_cmd(OP_INSERT, TIME_W'(h * 60), TIME_W'(h * 60 + 60), ROOM_W'(h), 0);
    end
    send_cmd(OP_FIND, 0, 0, 0, 24);

    // Slow receiver
    src_idle_pct = 28;
    sink_stall_pct <= 80;
    for (k = 0; k < PHASE_ITEMS; k++) send_random(((k / 100) % 2 == 0) ? 55 : 30);

    // Slow sender
    src_idle_pct = 80;
    sink_stall_pct <= 28;
    for (k = 0; k < PHASE_ITEMS; k++) send_random(((k / 100) % 2 == 0) ? 55 : 30);

    // Full rate, opening with a long receiver hold-off
    src_idle_pct = 0;
    sink_stall_pct <= 0;
    burst_req <= 1'b1;
    for (k = 0; k < PHASE_ITEMS; k++) send_random(((k / 100) % 2 == 0) ? 55 : 30);
    in_valid_i <= 1'b0;

    // Drain outstanding results, then let the pipeline settle
    while (sb.awaited_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.errors == 0 && sb.awaited_results.size() == 0) begin
      $display("PASS sorted_interval_reservation_table");
    end else begin
      $display("FAIL sorted_interval_reservation_table");
    end
    $finish;
  end
endmodule
